@@ src/rrte_pkg.sv @@
// ----------------------------------------------------------------------------
// rrte_pkg: shared types and constants
// Command, status and register codes, memory sizes and arithmetic widths for
// the tree extend step core.
// ----------------------------------------------------------------------------
package rrte_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_AW   = 10;
    localparam int CNT_W     = 11;
    localparam int MAP_DEPTH = 4096;
    localparam int MAP_AW    = 12;
    localparam int COORD_W   = 9;
    localparam int DSQ_W     = 20;

    // iterative divide / square root widths
    localparam int NUM_W = 28;
    localparam int DEN_W = 18;
    localparam int Q_W   = 10;
    localparam int QK_W  = 4;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_EXTEND = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_BLOCKED  = 3'd2;
    localparam logic [2:0] ST_NO_NEIGH = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [2:0] REG_STEP   = 3'd0;
    localparam logic [2:0] REG_SRAD   = 3'd1;
    localparam logic [2:0] REG_GOAL_X = 3'd2;
    localparam logic [2:0] REG_GOAL_Y = 3'd3;
    localparam logic [2:0] REG_GRAD   = 3'd4;

    // absolute difference of two coordinates
    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        begin
            d = {1'b0, a} - {1'b0, b};
            abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        end
    endfunction

endpackage

@@ src/rrte_div.sv @@
// ----------------------------------------------------------------------------
// rrte_div: restoring divider
// Unsigned divide, one quotient bit per cycle; the quotient must fit Q_W bits.
// ----------------------------------------------------------------------------
module rrte_div
    import rrte_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [QK_W-1:0]  r_k;
    logic [NUM_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic [NUM_W-1:0] den_sh;

    assign den_sh = {{(NUM_W-DEN_W){1'b0}}, i_den} << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_num;
                r_q    <= '0;
                r_k    <= QK_W'(Q_W - 1);
            end else if (r_busy) begin
                if (r_rem >= den_sh) begin
                    r_rem      <= r_rem - den_sh;
                    r_q[r_k]   <= 1'b1;
                end
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ src/rrt_tree_extend_step_core.sv @@
// Load and start go through S_OUT to the output register; read passes S_RDA and
// S_RDB first; extend scans the tree and, for a steered sample, runs the square
// root and two divides before the map check. One word at a time: the node scan
// walks the tree memory one node per cycle. Synchronous active-low reset clears
// the tree count, the reached flag and the registers to their defaults; map and
// node memories are undefined until written.
// ----------------------------------------------------------------------------
// rrt_tree_extend_step_core: tree extend step engine
// Holds the free-space map and node tree, runs load, start, extend and read
// commands through a small sequencer with an iterative root and shared divider.
// ----------------------------------------------------------------------------
module rrt_tree_extend_step_core
    import rrte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [9:0]          i_cfg_data,
    // command words
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_command,
    input  logic [8:0]          i_sample_x,
    input  logic [8:0]          i_sample_y,
    input  logic [11:0]         i_index,
    input  logic [63:0]         i_map_word,
    // result words
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [8:0]          o_node_x,
    output logic [8:0]          o_node_y,
    output logic [9:0]          o_parent_index,
    output logic [10:0]         o_node_index,
    output logic                o_goal_reached
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_DIVX  = 4'd3;
    localparam logic [3:0] S_DIVY  = 4'd4;
    localparam logic [3:0] S_MAPRD = 4'd5;
    localparam logic [3:0] S_MAPCK = 4'd6;
    localparam logic [3:0] S_RDA   = 4'd7;
    localparam logic [3:0] S_RDB   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // configuration registers
    logic [5:0]  r_step;
    logic [9:0]  r_srad;
    logic [8:0]  r_gx;
    logic [8:0]  r_gy;
    logic [9:0]  r_grad;

    logic [3:0]  r_state;
    logic [8:0]  r_sx;
    logic [8:0]  r_sy;
    logic [11:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic        r_reached;

    // memories
    logic [63:0] r_map [MAP_DEPTH];
    logic [63:0] r_mq;
    logic [27:0] r_tree [MAX_NODES];
    logic [27:0] r_tq;

    // scan state
    logic [CNT_W-1:0]   r_i;
    logic               r_pv;
    logic [NODE_AW-1:0] r_pidx;
    logic [DSQ_W-1:0]   r_best;
    logic [NODE_AW-1:0] r_near;
    logic [8:0]         r_bx;
    logic [8:0]         r_by;
    logic               r_found;

    // steering
    logic [DEN_W-1:0] r_root;
    logic [4:0]       r_sk;
    logic             r_div_go;
    logic [Q_W-1:0]   r_nx;
    logic [Q_W-1:0]   r_ny;

    // pending result
    logic [2:0]  r_rst;
    logic [8:0]  r_rx;
    logic [8:0]  r_ry;
    logic [9:0]  r_rpar;
    logic [10:0] r_ridx;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_ostatus;
    logic [8:0]  r_ox;
    logic [8:0]  r_oy;
    logic [9:0]  r_opar;
    logic [10:0] r_oidx;
    logic        r_oreach;

    logic               in_acc;
    logic               scan_more;
    logic [NODE_AW-1:0] tree_raddr;
    logic [MAP_AW-1:0]  map_addr;
    logic [DSQ_W-1:0]   node_dsq;
    logic [8:0]         adx;
    logic [8:0]         ady;
    logic [DSQ_W-1:0]   srad_sq;
    logic [DSQ_W-1:0]   step_sq;
    logic [DSQ_W-1:0]   grad_sq;
    logic [DSQ_W-1:0]   goal_dsq;
    logic [8:0]         gdx;
    logic [8:0]         gdy;
    logic [DEN_W-1:0]   trial;
    logic [35:0]        trial_sq;
    logic [8:0]         st_n;
    logic [8:0]         st_s;
    logic [26:0]        prod_nd;
    logic signed [9:0]  delta;
    logic signed [16:0] sdel;
    logic signed [28:0] num_s;
    logic [NUM_W-1:0]   div_num;
    logic               div_done;
    logic [Q_W-1:0]     div_q;
    logic               out_free;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign scan_more = (r_i < r_count);

    // tree read address: scan walks slots, read command uses the index
    assign tree_raddr = (r_state == S_SCAN) ? r_i[NODE_AW-1:0] : r_idx[NODE_AW-1:0];
    assign map_addr   = {r_ny[8:0], r_nx[8:6]};

    // squared distance of the node just read to the sample
    assign adx      = abs_diff(r_sx, r_tq[27:19]);
    assign ady      = abs_diff(r_sy, r_tq[18:10]);
    assign node_dsq = DSQ_W'(adx * adx) + DSQ_W'(ady * ady);
    assign srad_sq  = r_srad * r_srad;
    assign step_sq  = DSQ_W'(r_step * r_step);
    assign grad_sq  = r_grad * r_grad;
    assign gdx      = abs_diff(r_nx[8:0], r_gx);
    assign gdy      = abs_diff(r_ny[8:0], r_gy);
    assign goal_dsq = DSQ_W'(gdx * gdx) + DSQ_W'(gdy * gdy);

    // square root: set one root bit per cycle, keep it if trial^2 fits
    assign trial    = r_root | (DEN_W'(1) << r_sk);
    assign trial_sq = trial * trial;

    // steering numerator n*d + step*delta*256, clamp negative to zero
    assign st_n    = (r_state == S_DIVX) ? r_bx : r_by;
    assign st_s    = (r_state == S_DIVX) ? r_sx : r_sy;
    assign prod_nd = st_n * r_root;
    assign delta   = $signed({1'b0, st_s}) - $signed({1'b0, st_n});
    assign sdel    = $signed({1'b0, r_step}) * delta;
    assign num_s   = $signed({2'b0, prod_nd}) + $signed({{4{sdel[16]}}, sdel, 8'b0});
    assign div_num = num_s[28] ? '0 : num_s[NUM_W-1:0];

    rrte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (div_num),
        .i_den   (r_root),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // map memory: one write port at load, registered read for the free test
    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == CMD_LOAD) begin
            r_map[i_index] <= i_map_word;
        end
        r_mq <= r_map[map_addr];
    end

    // node memory: {x, y, parent}
    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == CMD_START) begin
            r_tree[0] <= {i_sample_x, i_sample_y, 10'd0};
        end else if (r_state == S_MAPCK && r_mq[r_nx[5:0]]) begin
            r_tree[r_count[NODE_AW-1:0]] <= {r_nx[8:0], r_ny[8:0], r_near};
        end
        r_tq <= r_tree[tree_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 6'd8;
            r_srad <= 10'd600;
            r_gx   <= '0;
            r_gy   <= '0;
            r_grad <= 10'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP:   r_step <= i_cfg_data[5:0];
                REG_SRAD:   r_srad <= i_cfg_data;
                REG_GOAL_X: r_gx   <= i_cfg_data[8:0];
                REG_GOAL_Y: r_gy   <= i_cfg_data[8:0];
                REG_GRAD:   r_grad <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_reached <= 1'b0;
            r_pv      <= 1'b0;
            r_div_go  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sx  <= i_sample_x;
                        r_sy  <= i_sample_y;
                        r_idx <= i_index;
                        r_rst  <= ST_OK;
                        r_rx   <= '0;
                        r_ry   <= '0;
                        r_rpar <= '0;
                        r_ridx <= '0;
                        r_state <= S_OUT;
                        case (i_command)
                            CMD_LOAD: ;
                            CMD_START: begin
                                r_count   <= CNT_W'(1);
                                r_reached <= 1'b0;
                                r_rx      <= i_sample_x;
                                r_ry      <= i_sample_y;
                            end
                            CMD_EXTEND: begin
                                if (r_count[CNT_W-1]) begin
                                    r_rst <= ST_FULL;
                                end else begin
                                    r_i     <= '0;
                                    r_pv    <= 1'b0;
                                    r_best  <= srad_sq;
                                    r_found <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_READ: begin
                                if (i_index < {1'b0, r_count}) begin
                                    r_state <= S_RDA;
                                end else begin
                                    r_rst <= ST_EMPTY;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // issue one slot a cycle, compare the one read last cycle
                    r_pv   <= scan_more;
                    r_pidx <= r_i[NODE_AW-1:0];
                    if (scan_more) begin
                        r_i <= r_i + 1'b1;
                    end
                    if (r_pv && node_dsq < r_best) begin
                        r_best  <= node_dsq;
                        r_near  <= r_pidx;
                        r_bx    <= r_tq[27:19];
                        r_by    <= r_tq[18:10];
                        r_found <= 1'b1;
                    end
                    if (!scan_more && !r_pv) begin
                        if (!r_found) begin
                            r_rst   <= ST_NO_NEIGH;
                            r_state <= S_OUT;
                        end else if (r_best <= step_sq) begin
                            r_nx    <= {1'b0, r_sx};
                            r_ny    <= {1'b0, r_sy};
                            r_state <= S_MAPRD;
                        end else begin
                            r_root  <= '0;
                            r_sk    <= 5'(DEN_W - 1);
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (trial_sq <= {r_best, 16'b0}) begin
                        r_root <= trial;
                    end
                    if (r_sk == '0) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIVX;
                    end else begin
                        r_sk <= r_sk - 1'b1;
                    end
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_nx     <= div_q;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_done) begin
                        r_ny    <= div_q;
                        r_state <= S_MAPRD;
                    end
                end
                S_MAPRD: begin
                    // off-map points are blocked without a map read
                    if (r_nx[9] || r_ny[9]) begin
                        r_rst   <= ST_BLOCKED;
                        r_rx    <= r_nx[8:0];
                        r_ry    <= r_ny[8:0];
                        r_rpar  <= r_near;
                        r_ridx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MAPCK;
                    end
                end
                S_MAPCK: begin
                    r_rx    <= r_nx[8:0];
                    r_ry    <= r_ny[8:0];
                    r_rpar  <= r_near;
                    r_state <= S_OUT;
                    if (r_mq[r_nx[5:0]]) begin
                        r_rst   <= ST_ADDED;
                        r_ridx  <= r_count;
                        r_count <= r_count + 1'b1;
                        if (goal_dsq < grad_sq) begin
                            r_reached <= 1'b1;
                        end
                    end else begin
                        r_rst  <= ST_BLOCKED;
                        r_ridx <= '0;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_rx    <= r_tq[27:19];
                    r_ry    <= r_tq[18:10];
                    r_rpar  <= r_tq[9:0];
                    r_ridx  <= r_idx[10:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: load when free, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid  <= 1'b1;
            r_ostatus <= r_rst;
            r_ox      <= r_rx;
            r_oy      <= r_ry;
            r_opar    <= r_rpar;
            r_oidx    <= r_ridx;
            r_oreach  <= r_reached;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_node_x       = r_ox;
    assign o_node_y       = r_oy;
    assign o_parent_index = r_opar;
    assign o_node_index   = r_oidx;
    assign o_goal_reached = r_oreach;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NODES))
        else $error("tree count beyond capacity");

    a_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_START) |=> (r_count == CNT_W'(1) && !r_reached))
        else $error("start did not reset the tree");

    a_scan_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_count[CNT_W-1])
        else $error("scan entered with full tree");
`endif

endmodule
